### src/jtm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jtm_pkg;

    // Defaults for the top-level parameters
    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int PID_BITS_DEF      = 22;

    // Fixed field widths
    localparam int FUNC_W   = 3;
    localparam int JNUM_W   = 16;
    localparam int STATE_W  = 2;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;

    localparam logic [JNUM_W-1:0]  JOB_NUMBER_MAX = 16'hFFFF;
    localparam logic [STATE_W-1:0] RS_FOREGROUND  = 2'd1;

    // Command codes
    typedef enum logic [FUNC_W-1:0] {
        FN_ADD      = 3'd0,
        FN_DELETE   = 3'd1,
        FN_SET      = 3'd2,
        FN_FIND_PID = 3'd3,
        FN_FIND_JOB = 3'd4
    } t_func;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_DONE = 2'd2
    } t_fsm;

endpackage

`default_nettype wire

### src/job_table_manager.sv
`timescale 1ns / 1ps
`default_nettype none

// Job table manager. Holds TABLE_ENTRIES job slots (pid, job number, run
// state) in one RAM with a used bit per slot; the table is empty right after
// reset. Each input word is one command: add, delete, set state by pid, find
// by pid or find by job number; it produces exactly one output word with
// status, slot, entry fields and the pid of the lowest foreground slot after
// the command. A command walks the RAM once, one slot per cycle, and finds
// its target, the foreground pid and the largest job number in that same
// pass; the write-back happens in the final cycle, together with the
// registering of the result word, which waits there while the output is
// blocked. The next command is taken only once the sequencer is back in
// idle, so a command is not taken before the last one is through, set by the
// single RAM read port. A finished result waits in the output register while
// the next command is already taken and scanned.
module job_table_manager #(
    parameter int TABLE_ENTRIES = jtm_pkg::TABLE_ENTRIES_DEF,
    parameter int PID_BITS      = jtm_pkg::PID_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    // tdata: func, process_id, job_number, run_state
    input  wire logic [((jtm_pkg::FUNC_W + PID_BITS + jtm_pkg::JNUM_W
                         + jtm_pkg::STATE_W + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    input  wire logic i_s_axis_tvalid,
    output logic      o_s_axis_tready,
    // tdata: status, slot_index, entry_process_id, entry_job_number,
    //        entry_run_state, foreground_process_id
    output logic [((jtm_pkg::STATUS_W + jtm_pkg::SLOT_W + 2 * PID_BITS
                    + jtm_pkg::JNUM_W + jtm_pkg::STATE_W + 7) / 8) * 8 - 1:0]
                      o_m_axis_tdata,
    output logic      o_m_axis_tvalid,
    input  wire logic i_m_axis_tready
);

    import jtm_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int ENTRY_W = PID_BITS + JNUM_W + STATE_W;
    localparam int OUT_RAW = STATUS_W + SLOT_W + 2 * PID_BITS + JNUM_W + STATE_W;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [JNUM_W:0]   ENTRIES_EXT = (JNUM_W + 1)'(TABLE_ENTRIES);

    // Input word fields
    logic [FUNC_W-1:0]   in_func;
    logic [PID_BITS-1:0] in_pid;
    logic [JNUM_W-1:0]   in_jnum;
    logic [STATE_W-1:0]  in_rs;

    assign in_func = i_s_axis_tdata[FUNC_W-1:0];
    assign in_pid  = i_s_axis_tdata[FUNC_W +: PID_BITS];
    assign in_jnum = i_s_axis_tdata[FUNC_W + PID_BITS +: JNUM_W];
    assign in_rs   = i_s_axis_tdata[FUNC_W + PID_BITS + JNUM_W +: STATE_W];

    t_fsm r_state, n_state;
    logic in_acc;
    logic done_go;

    // Command registers
    logic [FUNC_W-1:0]   r_func;
    logic [PID_BITS-1:0] r_pid;
    logic [JNUM_W-1:0]   r_jnum;
    logic [STATE_W-1:0]  r_rs;
    logic                r_active;

    // Scan pipeline
    logic [IDX_W-1:0] r_rd_addr;
    logic             r_rd_on;
    logic [IDX_W-1:0] r_chk_idx;
    logic             r_chk_vld;

    // Scan accumulators
    logic                r_found;
    logic [IDX_W-1:0]    r_slot;
    logic [ENTRY_W-1:0]  r_rep;
    logic [ENTRY_W-1:0]  r_mod;
    logic                r_fg_found;
    logic [PID_BITS-1:0] r_fg_pid;
    logic [JNUM_W-1:0]   r_max;
    logic [JNUM_W-1:0]   r_next_jn;

    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;

    // Table read side
    logic [ENTRY_W-1:0]  rd_data;
    logic                rd_used;
    logic                wr_en;
    logic                clr_en;

    jtm_table #(
        .ENTRIES (TABLE_ENTRIES),
        .ENTRY_W (ENTRY_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (rd_data),
        .o_rd_used (rd_used),
        .i_wr_en   (wr_en),
        .i_clr_en  (clr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (r_mod)
    );

    // Unpacked view of the slot being checked
    logic [PID_BITS-1:0] o_pid;
    logic [JNUM_W-1:0]   o_jnum;

    assign o_pid  = rd_data[PID_BITS-1:0];
    assign o_jnum = rd_data[PID_BITS +: JNUM_W];

    // Per-slot evaluation: match, modified entry, effective entry after the command
    logic               match;
    logic               hit;
    logic [ENTRY_W-1:0] mod_entry;
    logic               mod_used;
    logic [ENTRY_W-1:0] eff_entry;
    logic               eff_used;
    logic [ENTRY_W-1:0] rep_entry;

    always_comb begin
        match     = 1'b0;
        mod_entry = rd_data;
        mod_used  = rd_used;
        rep_entry = rd_data;
        case (r_func)
            FN_ADD: begin
                match     = !rd_used;
                mod_entry = {r_rs, r_next_jn, r_pid};
                mod_used  = 1'b1;
                rep_entry = mod_entry;
            end
            FN_DELETE: begin
                match     = rd_used && (o_pid == r_pid);
                mod_entry = '0;
                mod_used  = 1'b0;
            end
            FN_SET: begin
                match     = rd_used && (o_pid == r_pid);
                mod_entry = {r_rs, o_jnum, o_pid};
                rep_entry = mod_entry;
            end
            FN_FIND_PID: begin
                match = rd_used && (o_pid == r_pid);
            end
            FN_FIND_JOB: begin
                match = rd_used && (o_jnum == r_jnum);
            end
            default: begin
                match = 1'b0;
            end
        endcase
        hit       = r_chk_vld && r_active && match && !r_found;
        eff_entry = hit ? mod_entry : rd_data;
        eff_used  = hit ? mod_used : rd_used;
    end

    logic [STATE_W-1:0] eff_rs;
    logic [JNUM_W-1:0]  eff_jnum;

    assign eff_rs   = eff_entry[PID_BITS + JNUM_W +: STATE_W];
    assign eff_jnum = eff_entry[PID_BITS +: JNUM_W];

    // Sequencer
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign done_go         = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_chk_vld && (r_chk_idx == LAST_IDX)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (done_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Table writes only in the final cycle; the next scan starts later,
    // so a read never overlaps a pending write to the same slot
    assign wr_en  = done_go && r_found && ((r_func == FN_ADD) || (r_func == FN_SET));
    assign clr_en = done_go && r_found && (r_func == FN_DELETE);

    // Read address walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_on   <= 1'b0;
            r_rd_addr <= '0;
            r_chk_vld <= 1'b0;
        end else begin
            r_chk_vld <= r_rd_on;
            if (in_acc) begin
                r_rd_on   <= 1'b1;
                r_rd_addr <= '0;
            end else if (r_rd_on) begin
                if (r_rd_addr == LAST_IDX) begin
                    r_rd_on <= 1'b0;
                end else begin
                    r_rd_addr <= r_rd_addr + 1'b1;
                end
            end
        end
    end

    // Command capture and scan accumulators
    always_ff @(posedge i_clk) begin
        r_chk_idx <= r_rd_addr;
        if (in_acc) begin
            r_func     <= in_func;
            r_pid      <= in_pid;
            r_jnum     <= in_jnum;
            r_rs       <= in_rs;
            r_active   <= (in_func == FN_FIND_JOB) ? (in_jnum != '0) : (in_pid != '0);
            r_found    <= 1'b0;
            r_slot     <= '0;
            r_rep      <= '0;
            r_mod      <= '0;
            r_fg_found <= 1'b0;
            r_fg_pid   <= '0;
            r_max      <= '0;
        end else if (r_chk_vld) begin
            if (hit) begin
                r_found <= 1'b1;
                r_slot  <= r_chk_idx;
                r_rep   <= rep_entry;
                r_mod   <= mod_entry;
            end
            if (!r_fg_found && eff_used && (eff_rs == RS_FOREGROUND)) begin
                r_fg_found <= 1'b1;
                r_fg_pid   <= eff_entry[PID_BITS-1:0];
            end
            if (eff_used && (eff_jnum > r_max)) begin
                r_max <= eff_jnum;
            end
        end
    end

    // Job number counter
    logic [JNUM_W:0] add_next;
    logic [JNUM_W:0] del_next;

    assign add_next = {1'b0, r_next_jn} + 1'b1;
    assign del_next = {1'b0, r_max} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_jn <= JNUM_W'(1);
        end else if (wr_en && (r_func == FN_ADD)) begin
            r_next_jn <= (add_next > ENTRIES_EXT) ? JNUM_W'(1) : add_next[JNUM_W-1:0];
        end else if (clr_en) begin
            r_next_jn <= del_next[JNUM_W] ? JOB_NUMBER_MAX : del_next[JNUM_W-1:0];
        end
    end

    // Result word
    t_status res_status;

    always_comb begin
        if (r_found) begin
            res_status = ST_OK;
        end else if ((r_func == FN_ADD) && r_active) begin
            res_status = ST_FULL;
        end else begin
            res_status = ST_NOTFOUND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done_go) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_go) begin
            r_out_data <= OUT_W'({r_fg_pid, r_rep, SLOT_W'(r_slot), res_status});
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Checks
    a_rise_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside final cycle");

    a_write_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en || clr_en) |-> (r_state == S_DONE) && r_found && !(wr_en && clr_en))
        else $error("table write outside final cycle");

    a_next_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_jn != '0)
        else $error("job number counter is zero");

    a_no_read_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> !r_rd_on && !r_chk_vld)
        else $error("scan still running at write-back");

endmodule

`default_nettype wire

### src/jtm_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Job slot storage: one synchronous RAM plus a used bit per slot.
// A slot whose used bit is low reads back as all zero.
module jtm_table #(
    parameter int ENTRIES = 16,
    parameter int ENTRY_W = 40
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [$clog2(ENTRIES)-1:0] i_rd_addr,
    output logic      [ENTRY_W-1:0]         o_rd_data,
    output logic                            o_rd_used,
    input  wire logic                       i_wr_en,
    input  wire logic                       i_clr_en,
    input  wire logic [$clog2(ENTRIES)-1:0] i_wr_addr,
    input  wire logic [ENTRY_W-1:0]         i_wr_data
);

    logic [ENTRY_W-1:0] r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_used;
    logic [ENTRY_W-1:0] r_rd_data;
    logic               r_rd_used;

    // RAM port: write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // Used bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_rd_used <= 1'b0;
        end else begin
            r_rd_used <= r_used[i_rd_addr];
            if (i_wr_en) begin
                r_used[i_wr_addr] <= 1'b1;
            end else if (i_clr_en) begin
                r_used[i_wr_addr] <= 1'b0;
            end
        end
    end

    assign o_rd_used = r_rd_used;
    assign o_rd_data = r_rd_used ? r_rd_data : '0;

endmodule

`default_nettype wire

### tb/job_table_checker.sv
`timescale 1ns / 1ps

// Watches the command and result streams of the job table, keeps its own
// copy of the table, and compares every result word with the oldest
// prediction still waiting.
module job_table_checker #(
    parameter int CMD_W = 48,
    parameter int RES_W = 72
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // command word: func, process_id, job_number, run_state
    input  logic [CMD_W-1:0] i_cmd_tdata,
    input  logic             i_cmd_tvalid,
    input  logic             i_cmd_tready,
    // result word: status, slot_index, entry_process_id, entry_job_number,
    //              entry_run_state, foreground_process_id
    input  logic [RES_W-1:0] i_res_tdata,
    input  logic             i_res_tvalid,
    input  logic             i_res_tready,
    output int               o_error_count,
    output int               o_pending
);
    import jtm_pkg::*;

    localparam int PID_W      = PID_BITS_DEF;
    localparam int TABLE_N    = TABLE_ENTRIES_DEF;
    localparam int PRINT_CAP  = 100;

    typedef struct packed {
        logic [STATE_W-1:0] run_state;
        logic [JNUM_W-1:0]  job_number;
        logic [PID_W-1:0]   process_id;
        logic [FUNC_W-1:0]  func;
    } cmd_word_t;

    typedef struct packed {
        logic [PID_W-1:0]    fg_pid;
        logic [STATE_W-1:0]  run_state;
        logic [JNUM_W-1:0]   job_number;
        logic [PID_W-1:0]    entry_pid;
        logic [SLOT_W-1:0]   slot;
        logic [STATUS_W-1:0] status;
    } job_result_t;

    // Shadow job table
    logic [PID_W-1:0]   slot_pid   [TABLE_N];
    logic [JNUM_W-1:0]  slot_jnum  [TABLE_N];
    logic [STATE_W-1:0] slot_state [TABLE_N];
    int unsigned        next_job;

    job_result_t expected_results[$];
    job_result_t got_word;
    job_result_t want_word;
    cmd_word_t   cmd_word;
    int          result_index = 0;

    initial o_error_count = 0;
    initial o_pending     = 0;

    task automatic report_mismatch(input string msg);
        if (o_error_count < PRINT_CAP)
            $display("[%0t] result %0d: %s", $time, result_index, msg);
        o_error_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got_v,
                               input int unsigned want_v);
        if (got_v != want_v)
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got_v, want_v));
    endtask

    // Lowest slot holding this pid, -1 if none or pid is zero
    function automatic int locate_pid(input logic [PID_W-1:0] pid);
        int hit;
        hit = -1;
        if (pid != '0)
            for (int i = TABLE_N - 1; i >= 0; i--)
                if (slot_pid[i] == pid)
                    hit = i;
        return hit;
    endfunction

    // Applies one command to the shadow table and returns the result word
    function automatic job_result_t apply_job_command(input cmd_word_t cmd);
        job_result_t res;
        int          hit;
        int unsigned top_jnum;
        res        = '0;
        res.status = ST_NOTFOUND;
        hit        = -1;
        case (cmd.func)
            FN_ADD: begin
                if (cmd.process_id != '0) begin
                    res.status = ST_FULL;
                    for (int i = TABLE_N - 1; i >= 0; i--)
                        if (slot_pid[i] == '0)
                            hit = i;
                    if (hit >= 0) begin
                        slot_pid[hit]   = cmd.process_id;
                        slot_state[hit] = cmd.run_state;
                        slot_jnum[hit]  = next_job[JNUM_W-1:0];
                        next_job++;
                        if (next_job > TABLE_N)
                            next_job = 1;
                    end
                end
            end
            FN_DELETE, FN_SET, FN_FIND_PID: begin
                hit = locate_pid(cmd.process_id);
                if (hit >= 0 && cmd.func == FN_SET)
                    slot_state[hit] = cmd.run_state;
            end
            FN_FIND_JOB: begin
                if (cmd.job_number != '0)
                    for (int i = TABLE_N - 1; i >= 0; i--)
                        if (slot_pid[i] != '0 && slot_jnum[i] == cmd.job_number)
                            hit = i;
            end
            default: ;
        endcase

        if (hit >= 0) begin
            res.status     = ST_OK;
            res.slot       = hit[SLOT_W-1:0];
            res.entry_pid  = slot_pid[hit];
            res.job_number = slot_jnum[hit];
            res.run_state  = slot_state[hit];
        end

        // delete reports the entry as it was, then recomputes the counter
        if (hit >= 0 && cmd.func == FN_DELETE) begin
            slot_pid[hit]   = '0;
            slot_jnum[hit]  = '0;
            slot_state[hit] = '0;
            top_jnum = 0;
            for (int i = 0; i < TABLE_N; i++)
                if (slot_jnum[i] > top_jnum)
                    top_jnum = slot_jnum[i];
            next_job = (top_jnum + 1 > JOB_NUMBER_MAX) ? JOB_NUMBER_MAX : top_jnum + 1;
        end

        // lowest foreground slot after the command
        for (int i = TABLE_N - 1; i >= 0; i--)
            if (slot_pid[i] != '0 && slot_state[i] == RS_FOREGROUND)
                res.fg_pid = slot_pid[i];
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_N; i++) begin
                slot_pid[i]   = '0;
                slot_jnum[i]  = '0;
                slot_state[i] = '0;
            end
            next_job = 1;
            expected_results.delete();
        end else begin
            // results first: a word leaving now cannot belong to one entering now
            if (i_res_tvalid && i_res_tready) begin
                got_word = i_res_tdata[$bits(job_result_t)-1:0];
                if (expected_results.size() == 0) begin
                    report_mismatch("result word with nothing outstanding");
                end else begin
                    want_word = expected_results.pop_front();
                    check_field("status", got_word.status, want_word.status);
                    check_field("slot_index", got_word.slot, want_word.slot);
                    check_field("entry_process_id", got_word.entry_pid, want_word.entry_pid);
                    check_field("entry_job_number", got_word.job_number,
                                want_word.job_number);
                    check_field("entry_run_state", got_word.run_state, want_word.run_state);
                    check_field("foreground_process_id", got_word.fg_pid, want_word.fg_pid);
                end
                result_index++;
            end
            if (i_cmd_tvalid && i_cmd_tready) begin
                cmd_word = i_cmd_tdata[$bits(cmd_word_t)-1:0];
                expected_results.push_back(apply_job_command(cmd_word));
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

### tb/tb_job_table_manager.sv
`timescale 1ns / 1ps

module tb_job_table_manager;
    import jtm_pkg::*;

    localparam int PID_W    = PID_BITS_DEF;
    localparam int TABLE_N  = TABLE_ENTRIES_DEF;
    localparam int CMD_BITS = FUNC_W + PID_W + JNUM_W + STATE_W;
    localparam int CMD_W    = ((CMD_BITS + 7) / 8) * 8;
    localparam int RES_BITS = STATUS_W + SLOT_W + 2 * PID_W + JNUM_W + STATE_W;
    localparam int RES_W    = ((RES_BITS + 7) / 8) * 8;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_CMDS  = 1024;
    localparam int DRAIN_CYCLES = 50;
    // both sides run without idling for this range of sent words
    localparam int STEADY_FIRST = 150;
    localparam int STEADY_LAST  = 350;
    // receiver holds off once here, long enough to back up the input
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 300;

    localparam logic [FUNC_W-1:0]  FN_UNUSED_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0]  FN_UNUSED_LAST  = 3'd7;
    localparam logic [STATE_W-1:0] RS_UNDEFINED    = 2'd0;
    localparam logic [STATE_W-1:0] RS_BACKGROUND   = 2'd2;
    localparam logic [STATE_W-1:0] RS_STOPPED      = 2'd3;
    localparam logic [PID_W-1:0]   PID_MAX         = '1;

    typedef struct packed {
        logic [STATE_W-1:0] run_state;
        logic [JNUM_W-1:0]  job_number;
        logic [PID_W-1:0]   process_id;
        logic [FUNC_W-1:0]  func;
    } cmd_word_t;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic [CMD_W-1:0] cmd_tdata  = '0;
    logic             cmd_tvalid = 1'b0;
    logic             cmd_tready;
    logic [RES_W-1:0] res_tdata;
    logic             res_tvalid;
    logic             res_tready = 1'b0;

    int error_count;
    int pending;
    int cycle_count = 0;
    int sent_count  = 0;

    always #2 clk = ~clk;

    job_table_manager uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tdata  (cmd_tdata),
        .i_s_axis_tvalid (cmd_tvalid),
        .o_s_axis_tready (cmd_tready),
        .o_m_axis_tdata  (res_tdata),
        .o_m_axis_tvalid (res_tvalid),
        .i_m_axis_tready (res_tready)
    );

    job_table_checker #(
        .CMD_W (CMD_W),
        .RES_W (RES_W)
    ) checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cmd_tdata   (cmd_tdata),
        .i_cmd_tvalid  (cmd_tvalid),
        .i_cmd_tready  (cmd_tready),
        .i_res_tdata   (res_tdata),
        .i_res_tvalid  (res_tvalid),
        .i_res_tready  (res_tready),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    // Run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic bit in_steady_stretch();
        return sent_count >= STEADY_FIRST && sent_count < STEADY_LAST;
    endfunction

    // Offers one command word and returns at the edge it is taken.
    // tvalid stays high into the next word unless an idle gap is chosen.
    task automatic send_cmd(input logic [FUNC_W-1:0] func, input logic [PID_W-1:0] pid,
                            input logic [JNUM_W-1:0] jnum, input logic [STATE_W-1:0] rs);
        cmd_word_t word;
        word.func       = func;
        word.process_id = pid;
        word.job_number = jnum;
        word.run_state  = rs;
        if (!in_steady_stretch() && $urandom_range(0, 99) < 30) begin
            cmd_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < 30)
                @(posedge clk);
        end
        cmd_tdata  <= CMD_W'(word);
        cmd_tvalid <= 1'b1;
        @(posedge clk);
        while (!cmd_tready)
            @(posedge clk);
        sent_count++;
    endtask

    // Mostly a small pool of pids so that commands hit existing entries
    function automatic logic [PID_W-1:0] pick_pid();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        else if (r < 85)
            return PID_W'($urandom_range(1, 24));
        else
            return PID_W'($urandom);
    endfunction

    function automatic logic [JNUM_W-1:0] pick_jnum();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return JNUM_W'($urandom_range(0, TABLE_N + 4));
        else
            return JNUM_W'($urandom);
    endfunction

    // Add-heavy stretches fill the table, delete-heavy ones drain it
    task automatic random_cmd(input bit add_heavy);
        int                r;
        int                add_cut;
        int                del_cut;
        logic [FUNC_W-1:0] func;
        add_cut = add_heavy ? 45 : 20;
        del_cut = add_cut + (add_heavy ? 12 : 35);
        r = $urandom_range(0, 99);
        if (r < add_cut)
            func = FN_ADD;
        else if (r < del_cut)
            func = FN_DELETE;
        else if (r < del_cut + 15)
            func = FN_SET;
        else if (r < del_cut + 27)
            func = FN_FIND_PID;
        else if (r < del_cut + 39)
            func = FN_FIND_JOB;
        else
            func = FUNC_W'($urandom_range(FN_UNUSED_FIRST, FN_UNUSED_LAST));
        send_cmd(func, pick_pid(), pick_jnum(), STATE_W'($urandom_range(0, 3)));
    endtask

    // Result side: random back-pressure, one long hold-off
    initial begin : result_ready
        bit hold_taken;
        hold_taken = 1'b0;
        forever begin
            @(posedge clk);
            if (sent_count >= HOLD_AT && !hold_taken) begin
                hold_taken = 1'b1;
                res_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                res_tready <= in_steady_stretch() || ($urandom_range(0, 99) >= 30);
            end
        end
    end

    initial begin : stimulus
        logic [PID_W-1:0] fill_pid;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: lookups miss, zero pid and unused code rejected
        send_cmd(FN_FIND_PID, PID_W'(1), '0, RS_UNDEFINED);
        send_cmd(FN_FIND_JOB, '0, '0, RS_UNDEFINED);
        send_cmd(FN_ADD, '0, '0, RS_FOREGROUND);
        send_cmd(FN_UNUSED_LAST, PID_MAX, '1, RS_STOPPED);

        // fill every slot; pid 1 goes in twice, several foreground entries
        for (int i = 0; i < TABLE_N; i++) begin
            if (i == 0)
                fill_pid = PID_MAX;
            else if (i == 2)
                fill_pid = PID_W'(1);
            else
                fill_pid = PID_W'(i);
            send_cmd(FN_ADD, fill_pid, '1, STATE_W'(i % 4));
        end
        send_cmd(FN_ADD, PID_W'(7), '0, RS_BACKGROUND);

        // delete at max pid, set state on a duplicate, job number extremes
        send_cmd(FN_DELETE, PID_MAX, '0, RS_UNDEFINED);
        send_cmd(FN_SET, PID_W'(1), '0, RS_FOREGROUND);
        send_cmd(FN_FIND_JOB, '0, JNUM_W'(TABLE_N), RS_UNDEFINED);
        send_cmd(FN_FIND_JOB, '0, '1, RS_UNDEFINED);
        send_cmd(FN_DELETE, PID_W'(99), '0, RS_STOPPED);

        for (int n = 0; n < RANDOM_CMDS; n++)
            random_cmd((n / 100) % 2 == 0);

        cmd_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
